[src/rcs_pkg.sv]
// Shared types and constants for the range to CIDR prefix splitter.
// No dependencies; every other file of the block imports this package.
package rcs_pkg;

  // Fixed field widths of the request and result channels
  localparam int FIELD_BITS = 32;
  localparam int LEN_BITS   = 6;

  // Depth of the request queue between front and back (power of two)
  localparam int QDEPTH = 2;

  // Most prefixes given for one request; only wider address settings can exceed it
  localparam int RESULT_CAP = 62;

  typedef struct packed {
    logic [FIELD_BITS-1:0] range_low;
    logic [FIELD_BITS-1:0] range_high;
  } rcs_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] prefix_addr;
    logic [LEN_BITS-1:0]   prefix_len;
    logic                  last_prefix;
  } rcs_out_t;

  // Queue status seen by both its producer and its consumer
  typedef struct packed {
    logic full;
    logic nempty;
  } rcs_qstat_t;

endpackage

[src/range_to_cidr_splitter.sv]
// Range to CIDR splitter: takes an inclusive address range and returns the
// minimal ascending list of aligned prefixes that covers it, the final one
// flagged by last_prefix; a range whose low is not below its high gives no
// prefix. Requests pass a front stage into a two-entry queue, so new ranges
// are taken while the back still walks an earlier one. The back tests one
// candidate block per cycle while the output register can take a prefix:
// a fitting block is a prefix, a misfit halves the size limit, and a
// 32-bit range gives up to 62 prefixes. Wider address settings stop after
// 62 prefixes, drop the rest and flag none of them by last_prefix.
// Depends on rcs_pkg, rcs_front, rcs_queue and rcs_back.
module range_to_cidr_splitter import rcs_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rcs_out_t out_data
);

  logic                   push, pop;
  logic [2*ADDR_BITS-1:0] push_data, pop_data;
  rcs_qstat_t             qstat;

  // request intake and classification
  rcs_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  rcs_queue #(.WIDTH(2 * ADDR_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // prefix walk
  rcs_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/rcs_queue.sv]
// Short request queue that decouples the front from the back of the splitter.
// Depends on rcs_pkg for its depth and status struct.
module rcs_queue import rcs_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output rcs_qstat_t       qstat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // status
  assign qstat.full   = (cnt_r == CW'(QDEPTH));
  assign qstat.nempty = (cnt_r != '0);
  assign pop_data     = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.nempty)
    else $error("queue read while empty");

endmodule

[src/rcs_front.sv]
// Front of the splitter: takes a request, trims it to the address width and
// drops empty ranges; non-empty ones go to the request queue. Uses rcs_pkg.
module rcs_front import rcs_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rcs_in_t                in_data,
  input  rcs_qstat_t             qstat,
  output logic                   push,
  output logic [2*ADDR_BITS-1:0] push_data
);

  logic                 vld_r, vld_nxt;
  logic                 keep_r;
  logic [ADDR_BITS-1:0] low_r, high_r;
  logic [ADDR_BITS-1:0] low_w, high_w;
  logic                 free_w, take_w;

  // trim or zero-extend to the address width
  assign low_w  = ADDR_BITS'(in_data.range_low);
  assign high_w = ADDR_BITS'(in_data.range_high);

  // stage empties when its request is dropped or moves into the queue
  assign push      = vld_r && keep_r && !qstat.full;
  assign push_data = {low_r, high_r};
  assign free_w    = !vld_r || !keep_r || !qstat.full;
  assign in_stall  = !free_w;
  assign take_w    = in_valid && free_w;

  always_comb begin
    vld_nxt = vld_r;
    if (take_w) begin
      vld_nxt = 1'b1;
    end else if (free_w) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload and classification: only low below high gives any prefix
  always_ff @(posedge clk) begin
    if (take_w) begin
      low_r  <= low_w;
      high_r <= high_w;
      keep_r <= (low_w < high_w);
    end
  end

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (low_r < high_r))
    else $error("empty range pushed to queue");

endmodule

[src/rcs_back.sv]
// Back of the splitter: walks one range per request, one candidate block a
// cycle unless stalled, and holds each prefix in an output register. Uses rcs_pkg.
module rcs_back import rcs_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rcs_qstat_t             qstat,
  output logic                   pop,
  input  logic [2*ADDR_BITS-1:0] pop_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rcs_out_t               out_data
);

  localparam int LW = $clog2(ADDR_BITS + 1);
  localparam int NW = $clog2(RESULT_CAP);

  logic                 busy_r, busy_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic [ADDR_BITS-1:0] top_r, top_nxt;
  logic [ADDR_BITS-1:0] lim_r, lim_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  rcs_out_t             out_r, out_nxt;

  logic [ADDR_BITS-1:0] cand, sum, hi;
  logic [LW-1:0]        ones, len_w;
  logic                 fits, is_last, out_space, step, emit, cap_hit, done;

  // candidate block: host bits below cur's lowest set bit, capped by limit
  always_comb begin
    cand    = ((cur_r - ADDR_BITS'(1)) & ~cur_r) & lim_r;
    sum     = cur_r + cand;
    fits    = (sum <= top_r);
    is_last = (sum == top_r);
    // mask is a run of low ones: its top bit gives the host bit count
    hi   = cand & ~(cand >> 1);
    ones = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (hi[i]) begin
        ones = ones | LW'(i + 1);
      end
    end
    len_w = LW'(ADDR_BITS) - ones;
  end

  // sequencing; the walk also ends once RESULT_CAP prefixes have gone out
  assign out_space = !out_vld_r || !out_stall;
  assign step      = busy_r && out_space;
  assign emit      = step && fits;
  assign cap_hit   = (cnt_r == NW'(RESULT_CAP - 1));
  assign done      = emit && (is_last || cap_hit);
  assign pop       = qstat.nempty && (!busy_r || done);

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    top_nxt  = top_r;
    lim_nxt  = lim_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = pop_data[2*ADDR_BITS-1:ADDR_BITS];
      top_nxt  = pop_data[ADDR_BITS-1:0];
      lim_nxt  = '1;
      cnt_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      if (fits) begin
        cur_nxt = sum + ADDR_BITS'(1);
        cnt_nxt = cnt_r + NW'(1);
      end else begin
        // too big now means too big for the rest of the range
        lim_nxt = cand >> 1;
      end
    end
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (emit) begin
      out_vld_nxt         = 1'b1;
      out_nxt.prefix_addr = FIELD_BITS'(cur_r);
      out_nxt.prefix_len  = LEN_BITS'(7'(len_w));
      out_nxt.last_prefix = is_last;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    top_r <= top_nxt;
    lim_r <= lim_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r <= top_r))
    else $error("current address passed range end");

  a_lim_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((lim_r & (lim_r + ADDR_BITS'(1))) == '0))
    else $error("size limit is not a low mask");

endmodule

[sim/tb_range_to_cidr_splitter.sv]
`timescale 1ns / 100ps
// Self-checking bench for range_to_cidr_splitter: drives address range requests with random
// gaps and stalls, predicts every prefix locally and checks each one as it leaves the block.
// Depends on rcs_pkg and the RTL of range_to_cidr_splitter.

// Expected prefixes per accepted request, checked in arrival order
class prefix_scoreboard;
  localparam int MAX_PREFIXES = 62;

  rcs_pkg::rcs_out_t want_q[$];
  int errors = 0;

  // One line per mismatch; printing is capped, counting is not
  task report(string msg);
    if (errors < 100) $display("%0t ERROR: %s", $realtime, msg);
    errors++;
  endtask

  // Split [range_low, range_high] into aligned blocks, lowest first
  function void note_range(rcs_pkg::rcs_in_t req);
    logic [31:0] cur, top, span, blk_end;
    rcs_pkg::rcs_out_t p;
    cur = req.range_low;
    top = req.range_high;
    if (cur >= top) return;  // empty or single-address range: nothing out
    for (int n = 0; n < MAX_PREFIXES; n++) begin
      // host bits below the lowest set bit; zero aligns to the whole space
      span = (cur == 32'd0) ? 32'hFFFF_FFFF : ((cur - 32'd1) & ~cur);
      // no carry here: span only covers bits below cur's lowest set bit
      while (cur + span > top) span = span >> 1;
      blk_end = cur + span;
      p.prefix_addr = cur;
      p.prefix_len  = 6'(32 - $countones(span));
      p.last_prefix = (blk_end == top);
      want_q.push_back(p);
      // stops on the block reaching high, so an all-ones end never wraps
      if (p.last_prefix) break;
      cur = blk_end + 32'd1;
    end
  endfunction

  task check_prefix(rcs_pkg::rcs_out_t got);
    rcs_pkg::rcs_out_t want;
    if (want_q.size() == 0) begin
      report($sformatf("unexpected prefix %h/%0d last=%b",
                       got.prefix_addr, got.prefix_len, got.last_prefix));
      return;
    end
    want = want_q.pop_front();
    if (got.prefix_addr !== want.prefix_addr)
      report($sformatf("prefix_addr got %h, expected %h", got.prefix_addr, want.prefix_addr));
    if (got.prefix_len !== want.prefix_len)
      report($sformatf("prefix_len at %h got %0d, expected %0d",
                       want.prefix_addr, got.prefix_len, want.prefix_len));
    if (got.last_prefix !== want.last_prefix)
      report($sformatf("last_prefix at %h got %b, expected %b",
                       want.prefix_addr, got.last_prefix, want.last_prefix));
  endtask

  function int pending();
    return want_q.size();
  endfunction
endclass

module tb_range_to_cidr_splitter;
  import rcs_pkg::*;

  localparam int RANDOM_RANGES = 200;
  localparam int CALM_TAIL     = 30;
  localparam int DRAIN_CYCLES  = 120;
  localparam int WATCHDOG_MAX  = 4000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  rcs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rcs_out_t out_data;

  prefix_scoreboard sb;
  int idle_pct   = 20;  // chance in percent of an idle burst, both sides
  bit calm       = 1'b0;
  int stall_left = 0;
  int dead_cycles = 0;

  range_to_cidr_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one request, hold it until taken, then maybe leave a gap
  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    rcs_in_t req;
    req.range_low  = lo;
    req.range_high = hi;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_range(req);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Result side: check what is taken, then choose next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_prefix(out_data);
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 4);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
    end
    if (dead_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo, hi, t, mask;
    int k;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: whole space, empty and single-address ranges, all-ones ends, worst split
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'h0000_0005, 32'h0000_0005);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h0000_0000, 32'h0000_0001);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'h0000_0007, 32'h0000_0008);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'h0A00_0000, 32'h0AFF_FFFF);
    send_range(32'hC0A8_0001, 32'hC0A8_00FE);
    send_range(32'h7FFF_FFFF, 32'h8000_0000);
    send_range(32'hFFFF_FFFD, 32'hFFFF_FFFF);

    // Random: mostly valid ranges of assorted shapes, some malformed ones
    for (int i = 0; i < RANDOM_RANGES; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (i >= RANDOM_RANGES - CALM_TAIL) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom;
          hi = $urandom;
        end
        1: begin  // high not above low
          lo = $urandom;
          hi = $urandom_range(0, 1) ? lo : lo - $urandom_range(1, 1000);
        end
        2, 3: begin
          lo = $urandom;
          hi = $urandom;
          if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
        end
        4, 5: begin  // short span from a random start
          lo = $urandom;
          t  = $urandom_range(1, 300);
          hi = (lo > 32'hFFFF_FFFF - t) ? 32'hFFFF_FFFF : lo + t;
        end
        6: begin  // aligned block, sometimes nudged off its base
          k    = $urandom_range(1, 31);
          mask = (32'd1 << k) - 32'd1;
          lo   = ($urandom & ~mask) + $urandom_range(0, 1);
          hi   = lo | mask;
        end
        7: begin
          lo = $urandom;
          hi = 32'hFFFF_FFFF;
        end
        8: begin
          lo = $urandom_range(0, 3);
          hi = $urandom >> $urandom_range(0, 31);
        end
        default: begin  // straddling a power of two
          k  = $urandom_range(1, 31);
          lo = (32'd1 << k) - $urandom_range(1, 2);
          hi = (32'd1 << k) + $urandom_range(0, 40);
        end
      endcase
      send_range(lo, hi);
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    // Drain, then give any stray prefix time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
